// ----- hdl/date_offset_by_days_top_defines.svh -----
// Assertion macros shared by the date offset block.
`ifndef DATE_OFFSET_BY_DAYS_TOP_DEFINES_SVH
`define DATE_OFFSET_BY_DAYS_TOP_DEFINES_SVH

// Condition a holds in the same cycle as trigger t.
`define DOBD_ASSERT_NOW(label, clk, rst, t, a) \
  label: assert property (@(posedge clk) disable iff (rst) (t) |-> (a)) \
    else $error("dobd: same-cycle check failed");

// Condition a holds in the cycle after trigger t.
`define DOBD_ASSERT_NEXT(label, clk, rst, t, a) \
  label: assert property (@(posedge clk) disable iff (rst) (t) |=> (a)) \
    else $error("dobd: next-cycle check failed");

`endif

// ----- hdl/dobd_pkg.sv -----
// Package: field widths, calendar constants and controller/datapath links.
`default_nettype none
package dobd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 16;
  localparam int YMOD_W  = 9;   // year mod 400
  localparam int STEP_W  = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
  localparam logic [YMOD_W-1:0]  YMOD_LAST  = YMOD_W'(399);
  localparam logic [STEP_W-1:0]  MOD_FIRST_STEP = STEP_W'(4);

  localparam logic CMD_ADD = 1'b0;

  typedef struct packed {
    logic idle;
    logic load;
    logic mod_step;
    logic check;
    logic walk;
    logic finish;
  } dobd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic mod_last;
    logic fin;
    logic out_busy;
  } dobd_sts_t;

  // Subtrahend for each restoring step of the year mod 400 reduction.
  function automatic logic [YEAR_W-1:0] mod_sub(input logic [STEP_W-1:0] k);
    logic [YEAR_W-1:0] v;
    case (k)
      3'd4:    v = YEAR_W'(6400);
      3'd3:    v = YEAR_W'(3200);
      3'd2:    v = YEAR_W'(1600);
      3'd1:    v = YEAR_W'(800);
      default: v = YEAR_W'(400);
    endcase
    return v;
  endfunction

  // Leap rule on the year reduced mod 400.
  function automatic logic leap_of(input logic [YMOD_W-1:0] r);
    logic century;
    century = (r == YMOD_W'(100)) || (r == YMOD_W'(200)) || (r == YMOD_W'(300));
    return (r == '0) || ((r[1:0] == 2'b00) && !century);
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] v;
    case (m)
      MONTH_FEB: v = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4:      v = DAY_W'(30);
      4'd6:      v = DAY_W'(30);
      4'd9:      v = DAY_W'(30);
      4'd11:     v = DAY_W'(30);
      default:   v = DAY_W'(31);
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/dobd_in_if.sv -----
// Request channel: direction, start date and day count.
`default_nettype none
interface dobd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [dobd_pkg::YEAR_W-1:0]  start_year;
  logic [dobd_pkg::MONTH_W-1:0] start_month;
  logic [dobd_pkg::DAY_W-1:0]   start_day;
  logic [dobd_pkg::COUNT_W-1:0] day_count;

  modport source (output valid, command, start_year, start_month, start_day, day_count,
                  input ready);
  modport sink (input valid, command, start_year, start_month, start_day, day_count,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/dobd_out_if.sv -----
// Response channel: resulting date and range flag.
`default_nettype none
interface dobd_out_if;
  logic                         valid;
  logic                         ready;
  logic [dobd_pkg::YEAR_W-1:0]  result_year;
  logic [dobd_pkg::MONTH_W-1:0] result_month;
  logic [dobd_pkg::DAY_W-1:0]   result_day;
  logic                         range_error;

  modport source (output valid, result_year, result_month, result_day, range_error,
                  input ready);
  modport sink (input valid, result_year, result_month, result_day, range_error,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/date_offset_by_days_top.sv -----
// Top level of the Gregorian date offset block.
// Moves a Gregorian date (year 1..9999) forward (command 0) or backward
// (command 1) by day_count days, one month per clock cycle, using the
// 4/100/400 leap-year rule. An item is accepted on request when valid and
// ready are high; the result appears on response with the same handshake.
// The year is first reduced mod 400, then the start date is checked and the
// months are walked; the time an item takes grows with the month boundaries
// crossed. The block works on one item at a time but accepts the next item
// while the previous result still waits in the output register. A start date
// that is not a valid calendar date, or a result outside years 1..9999, gives
// range_error high with the start date echoed back.
`default_nettype none
module date_offset_by_days_top (
  input  wire         clk,
  input  wire         rst,
  dobd_in_if.sink     request,
  dobd_out_if.source  response
);
  import dobd_pkg::*;

  dobd_cmd_t cmd;
  dobd_sts_t sts;

  // sequence each item: load, reduce year mod 400, check, walk months, deliver
  dobd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // hold the date being walked and the output register
  dobd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .request  (request),
    .response (response)
  );
endmodule
`default_nettype wire

// ----- hdl/dobd_ctrl.sv -----
// Controller: sequences load, year reduction, check and month walk.
`default_nettype none
`include "date_offset_by_days_top_defines.svh"
module dobd_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  dobd_pkg::dobd_sts_t  sts,
  output dobd_pkg::dobd_cmd_t  cmd
);
  import dobd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOD   = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.idle   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.fin) begin
          // hold the result until the output register is free
          if (!sts.out_busy) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.walk = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DOBD_ASSERT_NEXT(a_mod_to_check, clk, rst, (state == ST_MOD) && sts.mod_last, state == ST_CHECK)
  `DOBD_ASSERT_NEXT(a_finish_to_idle, clk, rst, cmd.finish, state == ST_IDLE)
  `DOBD_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.finish, !sts.out_busy)
endmodule
`default_nettype wire

// ----- hdl/dobd_dp.sv -----
// Datapath: date registers, year mod 400 unit, month step and output register.
`default_nettype none
`include "date_offset_by_days_top_defines.svh"
module dobd_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  dobd_pkg::dobd_cmd_t  cmd,
  output dobd_pkg::dobd_sts_t  sts,
  dobd_in_if.sink              request,
  dobd_out_if.source           response
);
  import dobd_pkg::*;

  logic                 dir;
  logic [YEAR_W-1:0]    y0, y, ymod;
  logic [MONTH_W-1:0]   m0, m;
  logic [DAY_W-1:0]     d0, d;
  logic [COUNT_W-1:0]   n;
  logic [STEP_W-1:0]    k;
  logic                 err, fin, out_valid;

  logic [YEAR_W-1:0]    sub;
  logic [YMOD_W-1:0]    r, r_inc, r_dec;
  logic [DAY_W-1:0]     dim_cur, left, d_prev_len;
  logic [DAY_W:0]       left_p1;
  logic                 bad;
  logic [MONTH_W-1:0]   m_dec;
  logic [YMOD_W-1:0]    r_back;

  assign sub     = mod_sub(k);
  assign r       = ymod[YMOD_W-1:0];
  assign r_inc   = (r == YMOD_LAST) ? '0 : r + YMOD_W'(1);
  assign r_dec   = (r == '0) ? YMOD_LAST : r - YMOD_W'(1);
  assign dim_cur = days_in(m, leap_of(r));
  assign left    = dim_cur - d;
  assign left_p1 = {1'b0, left} + (DAY_W+1)'(1);
  assign bad     = (y < YEAR_MIN) || (y > YEAR_MAX) || (m < MONTH_JAN) || (m > MONTH_DEC)
                   || (d == '0) || (d > dim_cur);
  // month and year residue after stepping back one month
  assign m_dec      = (m == MONTH_JAN) ? MONTH_DEC : m - MONTH_W'(1);
  assign r_back     = (m == MONTH_JAN) ? r_dec : r;
  assign d_prev_len = days_in(m_dec, leap_of(r_back));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dir  <= request.command;
      y0   <= request.start_year;
      m0   <= request.start_month;
      d0   <= request.start_day;
      y    <= request.start_year;
      m    <= request.start_month;
      d    <= request.start_day;
      n    <= request.day_count;
      ymod <= request.start_year;
      k    <= MOD_FIRST_STEP;
    end else if (cmd.mod_step) begin
      // one restoring step of year mod 400
      if (ymod >= sub) begin
        ymod <= ymod - sub;
      end
      k <= k - STEP_W'(1);
    end else if (cmd.walk) begin
      if (dir == CMD_ADD) begin
        if (n <= {{(COUNT_W-DAY_W){1'b0}}, left}) begin
          d <= d + n[DAY_W-1:0];
          n <= '0;
        end else begin
          n <= n - {{(COUNT_W-DAY_W-1){1'b0}}, left_p1};
          d <= DAY_W'(1);
          if (m == MONTH_DEC) begin
            m    <= MONTH_JAN;
            y    <= y + YEAR_W'(1);
            ymod <= {{(YEAR_W-YMOD_W){1'b0}}, r_inc};
          end else begin
            m <= m + MONTH_W'(1);
          end
        end
      end else begin
        if (n < {{(COUNT_W-DAY_W){1'b0}}, d}) begin
          d <= d - n[DAY_W-1:0];
          n <= '0;
        end else begin
          n    <= n - {{(COUNT_W-DAY_W){1'b0}}, d};
          m    <= m_dec;
          d    <= d_prev_len;
          ymod <= {{(YEAR_W-YMOD_W){1'b0}}, r_back};
          if (m == MONTH_JAN) begin
            y <= y - YEAR_W'(1);
          end
        end
      end
    end
  end

  // control flags: error and walk finished
  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
      fin <= 1'b0;
    end else if (cmd.load) begin
      err <= 1'b0;
      fin <= 1'b0;
    end else if (cmd.check) begin
      err <= bad;
      fin <= bad;
    end else if (cmd.walk) begin
      if (dir == CMD_ADD) begin
        if (n <= {{(COUNT_W-DAY_W){1'b0}}, left}) begin
          fin <= 1'b1;
        end else if ((m == MONTH_DEC) && (y >= YEAR_MAX)) begin
          err <= 1'b1;
          fin <= 1'b1;
        end
      end else begin
        if (n < {{(COUNT_W-DAY_W){1'b0}}, d}) begin
          fin <= 1'b1;
        end else if ((m == MONTH_JAN) && (y <= YEAR_MIN)) begin
          err <= 1'b1;
          fin <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      response.result_year  <= err ? y0 : y;
      response.result_month <= err ? m0 : m;
      response.result_day   <= err ? d0 : d;
      response.range_error  <= err;
    end
  end

  assign response.valid = out_valid;
  assign request.ready  = cmd.idle;

  assign sts.in_valid = request.valid;
  assign sts.mod_last = (k == '0);
  assign sts.fin      = fin;
  assign sts.out_busy = out_valid && !response.ready;

  `DOBD_ASSERT_NOW(a_err_ends_walk, clk, rst, err, fin)
  `DOBD_ASSERT_NEXT(a_finish_loads_out, clk, rst, cmd.finish, response.valid)
  `DOBD_ASSERT_NEXT(a_out_holds, clk, rst, response.valid && !response.ready, response.valid)
endmodule
`default_nettype wire
